/* src/tbpf_pkg.sv */
package tbpf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = 20;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [3:0] BAND0_MAX_PRIO = 4'd3;
    localparam logic [3:0] BAND1_MAX_PRIO = 4'd6;
    localparam logic [3:0] BAND2_MAX_PRIO = 4'd9;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_QUEUE = 3'd4;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY,
        OP_REJECT
    } op_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  priority_req;
        logic [15:0] size_hundredths;
        logic [15:0] name_tag;
        logic [1:0]  queue_select;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       queue_index;
        logic [15:0]      removed_size;
        logic [15:0]      removed_tag;
        logic [3:0]       removed_priority;
        logic [4:0]       entry_count;
        logic [SUM_W-1:0] size_total;
    } out_beat_t;

    typedef struct packed {
        logic [3:0]  prio;
        logic [15:0] tag;
        logic [15:0] size;
    } entry_t;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [1:0]  target;
        entry_t      entry;
        out_beat_t   res;
    } work_t;

endpackage

/* src/tbpf_cell.sv */
module tbpf_cell
    import tbpf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [1:0] cell_id,
    input  work_t      work_in,
    output work_t      work_out
);

    entry_t           mem [QUEUE_DEPTH];
    entry_t           rd_data_reg;
    work_t            work_reg;
    work_t            work_next;
    logic             valid_reg;
    logic             pop_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_eff;
    logic [SUM_W-1:0] sum_next;
    logic             hit;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // A pop's size is subtracted once the stored entry has been read, while pop_reg is set.
    assign sum_eff = sum_reg - (pop_reg ? SUM_W'(rd_data_reg.size) : '0);
    assign hit     = work_in.valid && (work_in.op != OP_REJECT) && (work_in.target == cell_id);
    assign full    = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (occ_reg == '0);

    always_comb begin
        work_next = work_in;
        ins_ok    = 1'b0;
        pop_ok    = 1'b0;
        occ_next  = occ_reg;
        sum_next  = sum_eff;
        if (hit) begin
            work_next.res.queue_index = cell_id;
            work_next.res.status      = ST_OK;
            work_next.res.entry_count = 5'(occ_reg);
            work_next.res.size_total  = sum_eff;
            unique case (work_in.op)
                OP_INSERT: begin
                    if (full) begin
                        work_next.res.status = ST_FULL;
                    end else begin
                        ins_ok   = 1'b1;
                        occ_next = occ_reg + 1'b1;
                        sum_next = sum_eff + SUM_W'(work_in.entry.size);
                        work_next.res.entry_count = 5'(occ_next);
                        work_next.res.size_total  = sum_next;
                    end
                end
                OP_REMOVE: begin
                    if (empty) begin
                        work_next.res.status = ST_EMPTY;
                    end else begin
                        pop_ok   = 1'b1;
                        occ_next = occ_reg - 1'b1;
                        work_next.res.entry_count = 5'(occ_next);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pop_reg   <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            sum_reg   <= '0;
        end else if (en) begin
            valid_reg <= work_in.valid;
            pop_reg   <= pop_ok;
            occ_reg   <= occ_next;
            sum_reg   <= sum_next;
            if (ins_ok) begin
                tail_reg <= ptr_inc(tail_reg);
            end
            if (pop_ok) begin
                head_reg <= ptr_inc(head_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
            if (ins_ok) begin
                mem[tail_reg] <= work_in.entry;
            end
            if (pop_ok) begin
                rd_data_reg <= mem[head_reg];
            end
        end
    end

    always_comb begin
        work_out       = work_reg;
        work_out.valid = valid_reg;
        if (pop_reg) begin
            work_out.res.removed_size     = rd_data_reg.size;
            work_out.res.removed_tag      = rd_data_reg.tag;
            work_out.res.removed_priority = rd_data_reg.prio;
            work_out.res.size_total       = sum_eff;
        end
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == CNT_W'(QUEUE_DEPTH)) |-> (head_reg == tail_reg))
        else $error("full queue with unequal pointers");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(occ_reg) && $stable(sum_reg) && $stable(pop_reg)))
        else $error("queue state changed during a stall");

endmodule

/* src/three_band_priority_fifo_top.sv */
// Path: each command beat is registered in every queue cell in turn before m_valid.
// Throughput: one command beat per cycle; each queue cell takes in a new beat as it
// passes on the last, and the chain stalls as a whole while a result waits on m_ready.
// Reset: synchronous, active low; clears pointers, counts, size sums and valid flags.
// Entry storage is not cleared and holds data only once written.
module three_band_priority_fifo_top
    import tbpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    work_t chain [NUM_QUEUES + 1];
    work_t entry_work;
    logic  en;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        entry_work              = '0;
        entry_work.valid        = s_valid;
        entry_work.entry.prio   = s_data.priority_req;
        entry_work.entry.tag    = s_data.name_tag;
        entry_work.entry.size   = s_data.size_hundredths;
        entry_work.op           = OP_REJECT;
        entry_work.res.status   = ST_BAD_QUEUE;
        case (s_data.cmd) inside
            CMD_INSERT: begin
                entry_work.op = OP_INSERT;
                if (s_data.priority_req <= BAND0_MAX_PRIO) begin
                    entry_work.target = 2'd0;
                end else if (s_data.priority_req <= BAND1_MAX_PRIO) begin
                    entry_work.target = 2'd1;
                end else if (s_data.priority_req <= BAND2_MAX_PRIO) begin
                    entry_work.target = 2'd2;
                end else begin
                    entry_work.op         = OP_REJECT;
                    entry_work.res.status = ST_BAD_PRIO;
                end
            end
            CMD_REMOVE, CMD_QUERY: begin
                if (s_data.queue_select < 2'(NUM_QUEUES)) begin
                    entry_work.op     = (s_data.cmd == CMD_REMOVE) ? OP_REMOVE : OP_QUERY;
                    entry_work.target = s_data.queue_select;
                end
            end
            default: begin
            end
        endcase
    end

    assign chain[0] = entry_work;

    for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_cell
        tbpf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_id  (2'(i)),
            .work_in  (chain[i]),
            .work_out (chain[i+1])
        );
    end

    assign m_valid = chain[NUM_QUEUES].valid;
    assign m_data  = chain[NUM_QUEUES].res;

endmodule
